[rtl/ipal_pkg.sv]
package ipal_pkg;

  localparam int unsigned IdxW    = 8;
  localparam int unsigned ChanW   = 8;
  localparam int unsigned EntryW  = 15;
  localparam int unsigned Depth   = 256;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDatW = 32;

  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_PAIR   = 2'd2;
  localparam logic [1:0] OP_CURSOR = 2'd3;

  localparam logic [CfgIdxW-1:0] REG_KEY_COLOR        = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_USE_CURSOR_TABLE = 8'd1;

  localparam logic [ChanW-1:0] ALPHA_OPAQUE = 8'hff;

  typedef struct packed {
    logic [1:0]       op;
    logic             target_cursor;
    logic [IdxW-1:0]  entry_index;
    logic [IdxW-1:0]  second_index;
    logic [ChanW-1:0] red_in;
    logic [ChanW-1:0] green_in;
    logic [ChanW-1:0] blue_in;
  } in_t;

  typedef struct packed {
    logic [31:0]      pixel_word;
    logic [ChanW-1:0] red_out;
    logic [ChanW-1:0] green_out;
    logic [ChanW-1:0] blue_out;
    logic [ChanW-1:0] alpha_out;
  } out_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] op;
    logic       key_hit;
    logic       use_cursor;
  } ctl_t;

  function automatic logic [EntryW-1:0] pack555(logic [ChanW-1:0] r, logic [ChanW-1:0] g,
                                                logic [ChanW-1:0] b);
    return {r[7:3], g[7:3], b[7:3]};
  endfunction

  function automatic logic [ChanW-1:0] widen5(logic [4:0] v);
    return {v, v[4:2]};
  endfunction

endpackage

[rtl/ipal_screen_ram.sv]
module ipal_screen_ram (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [ipal_pkg::IdxW-1:0]     waddr_i,
  input  logic [ipal_pkg::EntryW-1:0]   wdata_i,
  input  logic                          re_i,
  input  logic [ipal_pkg::IdxW-1:0]     raddr_a_i,
  input  logic [ipal_pkg::IdxW-1:0]     raddr_b_i,
  output logic [ipal_pkg::EntryW-1:0]   rdata_a_o,
  output logic [ipal_pkg::EntryW-1:0]   rdata_b_o
);

  logic [ipal_pkg::EntryW-1:0] mem_q [ipal_pkg::Depth];
  logic [ipal_pkg::EntryW-1:0] rdata_a_q;
  logic [ipal_pkg::EntryW-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

[rtl/ipal_cursor_ram.sv]
module ipal_cursor_ram (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [ipal_pkg::IdxW-1:0]     waddr_i,
  input  logic [ipal_pkg::EntryW-1:0]   wdata_i,
  input  logic                          re_i,
  input  logic [ipal_pkg::IdxW-1:0]     raddr_i,
  output logic [ipal_pkg::EntryW-1:0]   rdata_o
);

  logic [ipal_pkg::EntryW-1:0] mem_q [ipal_pkg::Depth];
  logic [ipal_pkg::EntryW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/ipal_format.sv]
module ipal_format (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ipal_pkg::ctl_t                ctl_i,
  input  logic [ipal_pkg::EntryW-1:0]   screen_a_i,
  input  logic [ipal_pkg::EntryW-1:0]   screen_b_i,
  input  logic [ipal_pkg::EntryW-1:0]   cursor_i,
  output logic                          result_valid_o,
  output ipal_pkg::out_t                result_o
);

  ipal_pkg::out_t              result_d;
  ipal_pkg::out_t              result_q;
  logic                        valid_q;
  logic [ipal_pkg::EntryW-1:0] cur_entry;

  assign cur_entry = ctl_i.use_cursor ? cursor_i : screen_a_i;

  always_comb begin
    result_d = '0;
    case (ctl_i.op)
      ipal_pkg::OP_READ: begin
        result_d.red_out   = ipal_pkg::widen5(screen_a_i[14:10]);
        result_d.green_out = ipal_pkg::widen5(screen_a_i[9:5]);
        result_d.blue_out  = ipal_pkg::widen5(screen_a_i[4:0]);
        result_d.alpha_out = ipal_pkg::ALPHA_OPAQUE;
      end
      ipal_pkg::OP_PAIR: begin
        result_d.pixel_word = {1'b0, screen_b_i, 1'b0, screen_a_i};
      end
      ipal_pkg::OP_CURSOR: begin
        if (!ctl_i.key_hit) begin
          result_d.pixel_word = {16'h0000, 1'b1, cur_entry};
        end
      end
      default: begin
        result_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.valid) begin
      result_q <= result_d;
    end
  end

  assign result_valid_o = valid_q;
  assign result_o       = result_q;

endmodule

[rtl/indexed_palette_to_rgb555.sv]
// Each read result passes the table read register, then the format register, and strobes
// on result_valid_o once the format register has taken it.
// Throughput: one item per cycle; busy stays low, writes give no result.
// The result stands for one cycle only; the receiver cannot stall the block.
// Reset clears key_color to 0, use_cursor_table to 0 and the pipeline valids;
// both tables hold undefined data until written and are never cleared.
module indexed_palette_to_rgb555 (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  ipal_pkg::in_t                  in_i,
  output logic                           result_valid_o,
  output ipal_pkg::out_t                 result_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ipal_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [ipal_pkg::CfgDatW-1:0]   cfg_data_i
);

  logic [ipal_pkg::IdxW-1:0]   key_color_q;
  logic                        use_cursor_q;
  logic                        accept;
  logic                        is_write;
  logic [ipal_pkg::EntryW-1:0] wdata;
  logic [ipal_pkg::EntryW-1:0] screen_a;
  logic [ipal_pkg::EntryW-1:0] screen_b;
  logic [ipal_pkg::EntryW-1:0] cursor_rd;
  ipal_pkg::ctl_t              ctl_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start & ~busy;
  assign is_write    = (in_i.op == ipal_pkg::OP_WRITE);
  assign wdata       = ipal_pkg::pack555(in_i.red_in, in_i.green_in, in_i.blue_in);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_color_q  <= '0;
      use_cursor_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == ipal_pkg::REG_KEY_COLOR) begin
        key_color_q <= cfg_data_i[ipal_pkg::IdxW-1:0];
      end else if (cfg_index_i == ipal_pkg::REG_USE_CURSOR_TABLE) begin
        use_cursor_q <= cfg_data_i[0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q.valid <= accept & ~is_write;
      if (accept) begin
        ctl_q.op         <= in_i.op;
        ctl_q.key_hit    <= (in_i.entry_index == key_color_q);
        ctl_q.use_cursor <= use_cursor_q;
      end
    end
  end

  ipal_screen_ram u_screen_ram (
    .clk_i     (clk_i),
    .we_i      (accept & is_write & ~in_i.target_cursor),
    .waddr_i   (in_i.entry_index),
    .wdata_i   (wdata),
    .re_i      (accept & ~is_write),
    .raddr_a_i (in_i.entry_index),
    .raddr_b_i (in_i.second_index),
    .rdata_a_o (screen_a),
    .rdata_b_o (screen_b)
  );

  ipal_cursor_ram u_cursor_ram (
    .clk_i   (clk_i),
    .we_i    (accept & is_write & in_i.target_cursor),
    .waddr_i (in_i.entry_index),
    .wdata_i (wdata),
    .re_i    (accept & ~is_write),
    .raddr_i (in_i.entry_index),
    .rdata_o (cursor_rd)
  );

  ipal_format u_format (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl_q),
    .screen_a_i     (screen_a),
    .screen_b_i     (screen_b),
    .cursor_i       (cursor_rd),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule
